// ===== rtl/lfo_pkg.sv =====
`default_nettype none

package lfo_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_HELD,
    ST_HASH1,
    ST_HASH2,
    ST_HASH3,
    ST_HASH4,
    ST_WAVE,
    ST_TABLE,
    ST_SCALE,
    ST_OUT
  } state_t;

  // register indexes on the config port
  localparam logic [2:0] REG_WAVE_SELECT = 3'd0;
  localparam logic [2:0] REG_PHASE_STEP  = 3'd1;
  localparam logic [2:0] REG_START_PHASE = 3'd2;
  localparam logic [2:0] REG_DEPTH       = 3'd3;
  localparam logic [2:0] REG_CENTER      = 3'd4;
  localparam logic [2:0] REG_SEED        = 3'd5;

  // wave codes
  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
  localparam logic [2:0] WAVE_SAW      = 3'd2;
  localparam logic [2:0] WAVE_RAMP     = 3'd3;
  localparam logic [2:0] WAVE_SQUARE   = 3'd4;
  localparam logic [2:0] WAVE_SH       = 3'd5;

  // state memory entries
  localparam logic ENT_PHASE = 1'b0;  // {cycle_count, phase_acc}
  localparam logic ENT_HELD  = 1'b1;  // {zero, held_random}

  localparam int unsigned STATE_RAM_WIDTH = 64;
  localparam int unsigned STATE_RAM_DEPTH = 2;

  // hash multipliers
  localparam logic [31:0] HASH_K1 = 32'h9E37_79B9;
  localparam logic [31:0] HASH_K2 = 32'h85EB_CA6B;
  localparam logic [31:0] HASH_K3 = 32'h7FEB_352D;
  localparam logic [31:0] HASH_K4 = 32'h846C_A68B;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // reset values of the registers
  localparam logic [31:0] PHASE_STEP_RST = 32'h0010_0000;
  localparam logic [15:0] DEPTH_RST      = 16'd16384;
  localparam logic [15:0] CENTER_RST     = 16'd32768;
  localparam logic [15:0] DEPTH_MAX      = 16'd32768;

  // two more powers of x in Q30
  function automatic logic [63:0] sine_pow(input logic [63:0] t, input logic [63:0] x);
    logic [63:0] a;
    a = (t * x) >> 30;
    return (a * x) >> 30;
  endfunction

  // quarter-wave sample from angle x in Q30, Taylor series to x^15, Q15 out
  function automatic logic [15:0] sine_entry(input logic [63:0] x);
    logic [63:0] term;
    longint      sum;
    longint      v;
    term = x;
    sum  = longint'(x);
    term = sine_pow(term, x) / 64'd6;   sum = sum - longint'(term);
    term = sine_pow(term, x) / 64'd20;  sum = sum + longint'(term);
    term = sine_pow(term, x) / 64'd42;  sum = sum - longint'(term);
    term = sine_pow(term, x) / 64'd72;  sum = sum + longint'(term);
    term = sine_pow(term, x) / 64'd110; sum = sum - longint'(term);
    term = sine_pow(term, x) / 64'd156; sum = sum + longint'(term);
    term = sine_pow(term, x) / 64'd210; sum = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum + 64'sd16384) >>> 15;
    if (v > 32768) begin
      v = 32768;
    end
    return 16'(v);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lfo_ram.sv =====
`default_nettype none

module lfo_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/lfo_waveform_generator.sv =====
`default_nettype none

// Tick-driven low-frequency oscillator. Each input beat is one tick: tdata bit 0
// set reloads the start phase and cycle index 0, clear advances the 32-bit phase
// by phase_step. Every beat gives one output beat with the level (unsigned
// Q0.16), a wrap flag and the cycle index. Phase, cycle count and held random
// value live in a two-entry state memory with a registered read; the sequencer
// reads, updates and writes it back, then shapes and scales the wave. A tick
// passes READ, then HELD, or HASH1 to HASH4 when the sample-and-hold hash is
// redrawn (restart or wrap) as the four hash rounds share one 32x32 multiplier,
// then WAVE, TABLE, SCALE and OUT. The output register lets the next tick be
// taken while a result still waits. Config writes are only legal while idle.
module lfo_waveform_generator #(
  parameter int unsigned SINE_ENTRIES = 256,
  parameter int unsigned LEVEL_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  // input ticks
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata    // [15:0] level, [16] cycle_wrapped,
                                           // [48:17] cycle_number, [55:49] zero
);

  import lfo_pkg::*;

  localparam int unsigned IDX_W  = $clog2(SINE_ENTRIES + 1);
  localparam int unsigned IPROD_W = 30 + IDX_W;
  localparam int unsigned SHIFT  = 30 - LEVEL_BITS;
  localparam int unsigned SHL    = (LEVEL_BITS >= 16) ? LEVEL_BITS - 16 : 0;
  localparam int unsigned SHR    = (LEVEL_BITS < 16) ? 16 - LEVEL_BITS : 0;
  localparam logic signed [35:0] ROUND_HALF = 36'sd1 <<< (SHIFT - 1);
  localparam logic signed [35:0] LEVEL_MAX  = (36'sd1 <<< LEVEL_BITS) - 36'sd1;

  // config registers
  logic [2:0]  wave_sel;
  logic [31:0] phase_step;
  logic [31:0] start_phase;
  logic [15:0] depth;
  logic [15:0] center;
  logic [31:0] seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_sel    <= WAVE_SINE;
      phase_step  <= PHASE_STEP_RST;
      start_phase <= '0;
      depth       <= DEPTH_RST;
      center      <= CENTER_RST;
      seed        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WAVE_SELECT: wave_sel    <= cfg_wdata[2:0];
        REG_PHASE_STEP:  phase_step  <= cfg_wdata;
        REG_START_PHASE: start_phase <= cfg_wdata;
        REG_DEPTH:       depth       <= cfg_wdata[15:0];
        REG_CENTER:      center      <= cfg_wdata[15:0];
        REG_SEED:        seed        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // quarter-wave table, built at elaboration
  logic [15:0] sine_rom [SINE_ENTRIES + 1];

  for (genvar gi = 0; gi <= SINE_ENTRIES; gi++) begin : g_sine
    localparam logic [63:0] SX = (64'(gi) * HALF_PI_Q30) / SINE_ENTRIES;
    assign sine_rom[gi] = sine_entry(SX);
  end

  // state memory
  logic        ram_we;
  logic        ram_waddr;
  logic [63:0] ram_wdata;
  logic        ram_raddr;
  logic [63:0] ram_rdata;
  logic [1:0]  ent_valid;

  lfo_ram #(
    .WIDTH (STATE_RAM_WIDTH),
    .DEPTH (STATE_RAM_DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entries never written read as the reset state (all zero)
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (ram_we) begin
      ent_valid[ram_waddr] <= 1'b1;
    end
  end

  state_t state, state_next;

  logic        restart;
  logic [31:0] phase;
  logic [31:0] count;
  logic        wrapped;
  logic [31:0] held;
  logic [31:0] hacc;

  // phase update from the entry just read
  logic [63:0] ent_phase;
  logic [32:0] phase_sum;
  logic [31:0] phase_n;
  logic [31:0] count_n;
  logic        wrap_n;
  logic        need_hash;

  always_comb begin
    ent_phase = ent_valid[ENT_PHASE] ? ram_rdata : '0;
    phase_sum = {1'b0, ent_phase[31:0]} + {1'b0, phase_step};
    if (restart) begin
      phase_n   = start_phase;
      count_n   = '0;
      wrap_n    = 1'b0;
      need_hash = 1'b1;
    end else begin
      phase_n   = phase_sum[31:0];
      count_n   = ent_phase[63:32] + 32'(phase_sum[32]);
      wrap_n    = phase_sum[32];
      need_hash = phase_sum[32];
    end
  end

  // shared hash multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_full;
  logic [31:0] mul_p;
  logic [31:0] hash_mix;
  logic [31:0] hash_fin;

  assign mul_full = mul_a * mul_b;
  assign mul_p    = mul_full[31:0];
  assign hash_mix = hacc + mul_p;
  assign hash_fin = mul_p ^ (mul_p >> 16);

  // output register
  logic        out_valid;
  logic        out_load;
  logic [15:0] out_level;
  logic        out_wrapped;
  logic [31:0] out_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = ENT_PHASE;
    ram_wdata     = {count_n, phase_n};
    ram_raddr     = ENT_PHASE;
    mul_a         = seed;
    mul_b         = HASH_K1;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        ram_raddr  = ENT_HELD;
        ram_we     = 1'b1;
        state_next = need_hash ? ST_HASH1 : ST_HELD;
      end
      ST_HELD:  state_next = ST_WAVE;
      ST_HASH1: state_next = ST_HASH2;
      ST_HASH2: begin
        mul_a      = count;
        mul_b      = HASH_K2;
        state_next = ST_HASH3;
      end
      ST_HASH3: begin
        mul_a      = hacc;
        mul_b      = HASH_K3;
        state_next = ST_HASH4;
      end
      ST_HASH4: begin
        mul_a      = hacc;
        mul_b      = HASH_K4;
        ram_we     = 1'b1;
        ram_waddr  = ENT_HELD;
        ram_wdata  = {32'd0, hash_fin};
        state_next = ST_WAVE;
      end
      ST_WAVE:  state_next = ST_TABLE;
      ST_TABLE: state_next = ST_SCALE;
      ST_SCALE: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // wave shaping
  logic [IPROD_W-1:0]  idx_prod;
  logic [IDX_W-1:0]    idx_raw;
  logic [IDX_W-1:0]    sine_idx;
  logic                sine_neg;
  logic [16:0]         tri_t;
  logic signed [18:0]  tri_w;
  logic [49:0]         sh_num;
  logic [16:0]         sh_q0;
  logic [33:0]         sh_rem;
  logic [17:0]         sh_q;
  logic signed [16:0]  w_next;
  logic signed [16:0]  w_pre;
  logic signed [16:0]  w;
  logic [15:0]         sine_mag;
  logic signed [33:0]  prod;

  always_comb begin
    idx_prod = IPROD_W'(phase[29:0]) * IPROD_W'(SINE_ENTRIES);
    idx_raw  = idx_prod[30 +: IDX_W];

    tri_t = phase[31:15];
    unique case (phase[31:30])
      2'b00:        tri_w = 19'(signed'({2'b00, tri_t}));
      2'b01, 2'b10: tri_w = 19'sd65536 - 19'(signed'({2'b00, tri_t}));
      default:      tri_w = 19'(signed'({2'b00, tri_t})) - 19'sd131072;
    endcase

    // round(65536*h/(2^32-1)) via shift estimate plus one correction
    sh_num = {1'b0, held, 17'd0} + 50'h0_FFFF_FFFF;
    sh_q0  = sh_num[49:33];
    sh_rem = {1'b0, sh_num[32:0]} + {16'd0, sh_q0, 1'b0};
    sh_q   = {1'b0, sh_q0} + 18'(sh_rem >= 34'h1_FFFF_FFFE);

    unique case (wave_sel)
      WAVE_TRIANGLE: w_next = 17'(tri_w);
      WAVE_SAW:      w_next = 17'sd32768 - 17'(signed'({1'b0, phase[31:16]}));
      WAVE_RAMP:     w_next = 17'(signed'({1'b0, phase[31:16]})) - 17'sd32768;
      WAVE_SQUARE:   w_next = phase[31] ? -17'sd32768 : 17'sd32768;
      WAVE_SH:       w_next = 17'(signed'(sh_q) - 18'sd32768);
      default:       w_next = '0;
    endcase

    sine_mag = sine_rom[sine_idx];
  end

  // scaling and clamp
  logic [15:0]         depth_c;
  logic signed [35:0]  offset;
  logic signed [35:0]  center_q;
  logic signed [35:0]  level_sum;
  logic [LEVEL_BITS-1:0] level_c;

  always_comb begin
    depth_c   = (depth > DEPTH_MAX) ? DEPTH_MAX : depth;
    offset    = (36'(prod) + ROUND_HALF) >>> SHIFT;
    center_q  = signed'((36'(center) << SHL) >> SHR);
    level_sum = center_q + offset;
    if (level_sum < 0) begin
      level_c = '0;
    end else if (level_sum > LEVEL_MAX) begin
      level_c = LEVEL_MAX[LEVEL_BITS-1:0];
    end else begin
      level_c = level_sum[LEVEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          restart <= s_axis_tdata[0];
        end
      end
      ST_READ: begin
        phase   <= phase_n;
        count   <= count_n;
        wrapped <= wrap_n;
      end
      ST_HELD:  held <= ent_valid[ENT_HELD] ? ram_rdata[31:0] : '0;
      ST_HASH1: hacc <= mul_p;
      ST_HASH2: hacc <= hash_mix ^ (hash_mix >> 16);
      ST_HASH3: hacc <= mul_p ^ (mul_p >> 15);
      ST_HASH4: held <= hash_fin;
      ST_WAVE: begin
        sine_idx <= phase[30] ? IDX_W'(SINE_ENTRIES) - idx_raw : idx_raw;
        sine_neg <= phase[31];
        w_pre    <= w_next;
      end
      ST_TABLE: begin
        if (wave_sel == WAVE_SINE) begin
          w <= sine_neg ? -signed'({1'b0, sine_mag}) : signed'({1'b0, sine_mag});
        end else begin
          w <= w_pre;
        end
      end
      ST_SCALE: prod <= 34'(signed'({1'b0, depth_c}) * w);
      ST_OUT: begin
        if (out_load) begin
          out_level   <= 16'(level_c);
          out_wrapped <= wrapped;
          out_number  <= count;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_number, out_wrapped, out_level};

endmodule

`default_nettype wire

// ===== rtl/lfo_checker.sv =====
`default_nettype none

module lfo_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata
);

  // no result beat right out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat valid right after reset");

  // one tick in flight: ready drops after a beat is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second tick taken while one is in flight");

  // a result never appears in the cycle right after a tick is taken
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result beat too early after tick");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed");

endmodule

bind lfo_waveform_generator lfo_checker u_lfo_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import lfo_pkg::*;

  localparam int SINE_N          = 256;
  localparam int N_PHASES        = 13;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int RESTART_PCT     = 6;
  localparam int SETTLE_CYCLES   = 20;
  localparam int HOLD_CYCLES     = 300;
  localparam int QUIET_LIMIT     = 5000;

  // register indexes past the end of the map, writes there are dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  // wave codes with no wave behind them
  localparam logic [2:0] WAVE_SPARE_LO = 3'd6;
  localparam logic [2:0] WAVE_SPARE_HI = 3'd7;

  typedef struct {
    logic [15:0] level;
    logic        cycle_wrapped;
    logic [31:0] cycle_number;
  } osc_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_TICK, ROW_TICK_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [31:0] wdata;
    logic        restart;
    osc_result_t known;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [0] restart, [7:1] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // [15:0] level, [16] cycle_wrapped, [48:17] cycle_number

  // shadow of the register file
  logic [2:0]  sh_wave;
  logic [31:0] sh_step;
  logic [31:0] sh_start;
  logic [15:0] sh_depth;
  logic [15:0] sh_center;
  logic [31:0] sh_seed;

  // oscillator state as the block should hold it
  logic [31:0] osc_phase;
  logic [31:0] osc_cycles;
  logic [31:0] osc_held;

  int          quarter_wave [0:SINE_N];
  osc_result_t osc_results_due [$];
  dir_row_t    dir_rows [$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;
  bit          hold_request   = 1'b0;
  int          quiet_cycles   = 0;

  lfo_waveform_generator i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // quarter sine in Q15 from a fixed-point Taylor series up to x^15
  function automatic void fill_quarter_wave();
    longint unsigned ang;
    longint unsigned pw;
    longint          acc;
    longint          r;
    for (int i = 0; i <= SINE_N; i++) begin
      ang = (64'(i) * HALF_PI_Q30) / SINE_N;
      pw  = ang;
      acc = longint'(ang);
      for (int k = 1; k <= 7; k++) begin
        pw = (pw * ang) >> 30;
        pw = (pw * ang) >> 30;
        pw = pw / (4 * k * k + 2 * k);
        if (k % 2 == 1) begin
          acc = acc - longint'(pw);
        end else begin
          acc = acc + longint'(pw);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      r = (acc + 16384) >>> 15;
      quarter_wave[i] = (r > 32768) ? 32768 : int'(r);
    end
  endfunction

  function automatic logic [31:0] sah_hash(input logic [31:0] s, input logic [31:0] idx);
    logic [31:0] h;
    h = s * HASH_K1 + idx * HASH_K2;
    h = h ^ (h >> 16);
    h = h * HASH_K3;
    h = h ^ (h >> 15);
    h = h * HASH_K4;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic void osc_reset();
    sh_wave    = WAVE_SINE;
    sh_step    = PHASE_STEP_RST;
    sh_start   = '0;
    sh_depth   = DEPTH_RST;
    sh_center  = CENTER_RST;
    sh_seed    = '0;
    osc_phase  = '0;
    osc_cycles = '0;
    osc_held   = sah_hash(sh_seed, 32'd0);
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      REG_WAVE_SELECT: sh_wave   = val[2:0];
      REG_PHASE_STEP:  sh_step   = val;
      REG_START_PHASE: sh_start  = val;
      REG_DEPTH:       sh_depth  = val[15:0];
      REG_CENTER:      sh_center = val[15:0];
      REG_SEED:        sh_seed   = val;
      default: ;
    endcase
  endfunction

  // wave value in Q1.15 for phase p
  function automatic int wave_sample(input logic [31:0] p);
    int              t;
    int              idx;
    int              mag;
    longint unsigned num;
    t = int'(p >> 15);
    case (sh_wave)
      WAVE_SINE: begin
        idx = int'((64'(p[29:0]) * SINE_N) >> 30);
        mag = p[30] ? quarter_wave[SINE_N - idx] : quarter_wave[idx];
        return p[31] ? -mag : mag;
      end
      WAVE_TRIANGLE: begin
        if (p < 32'h4000_0000) begin
          return t;
        end else if (p < 32'hC000_0000) begin
          return 65536 - t;
        end
        return t - 131072;
      end
      WAVE_SAW:    return 32768 - int'(p >> 16);
      WAVE_RAMP:   return int'(p >> 16) - 32768;
      WAVE_SQUARE: return p[31] ? -32768 : 32768;
      WAVE_SH: begin
        num = (64'(osc_held) * 64'd131072 + 64'hFFFF_FFFF) / (64'd2 * 64'hFFFF_FFFF);
        return int'(num) - 32768;
      end
      default: return 0;
    endcase
  endfunction

  function automatic logic [15:0] scale_level(input int w);
    longint d;
    longint off;
    longint v;
    d   = (sh_depth > DEPTH_MAX) ? longint'(DEPTH_MAX) : longint'(sh_depth);
    // round half up from Q30 to Q0.16
    off = ((d * longint'(w) + (64'sd1 <<< 30) + (64'sd1 <<< 13)) >>> 14) - 64'sd65536;
    v   = longint'(sh_center) + off;
    if (v < 0) begin
      v = 0;
    end else if (v > 65535) begin
      v = 65535;
    end
    return 16'(v);
  endfunction

  function automatic osc_result_t osc_next_result(input logic rs);
    osc_result_t r;
    logic [32:0] sum;
    r.cycle_wrapped = 1'b0;
    if (rs) begin
      osc_phase  = sh_start;
      osc_cycles = '0;
      osc_held   = sah_hash(sh_seed, 32'd0);
    end else begin
      sum = {1'b0, osc_phase} + {1'b0, sh_step};
      if (sum[32]) begin
        r.cycle_wrapped = 1'b1;
        osc_cycles      = osc_cycles + 32'd1;
        osc_held        = sah_hash(sh_seed, osc_cycles);
      end
      osc_phase = sum[31:0];
    end
    r.level        = scale_level(wave_sample(osc_phase));
    r.cycle_number = osc_cycles;
    return r;
  endfunction

  function automatic void add_write(input logic [2:0] idx, input logic [31:0] val);
    dir_row_t row;
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.wdata   = val;
    row.restart = 1'b0;
    row.known   = '{default: '0};
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void add_tick(input logic rs);
    dir_row_t row;
    row.kind    = ROW_TICK;
    row.reg_idx = '0;
    row.wdata   = '0;
    row.restart = rs;
    row.known   = '{default: '0};
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void add_known(input logic rs, input logic [15:0] lvl, input logic wr,
                                    input logic [31:0] cyc);
    dir_row_t row;
    row.kind                = ROW_TICK_KNOWN;
    row.reg_idx             = '0;
    row.wdata               = '0;
    row.restart             = rs;
    row.known.level         = lvl;
    row.known.cycle_wrapped = wr;
    row.known.cycle_number  = cyc;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic send_tick(input logic rs, input bit known, input osc_result_t known_res);
    osc_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, rs};
    do @(posedge clk); while (!s_axis_tready);
    pred = osc_next_result(rs);
    if (known) begin
      pred = known_res;
    end
    osc_results_due.insert(osc_results_due.size(), pred);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (osc_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic randomize_regs();
    logic [31:0] step;
    logic [31:0] depth_val;
    case ($urandom_range(0, 5))
      0:       step = $urandom_range(1, 32'h0040_0000);
      1:       step = $urandom_range(32'h1000_0000, 32'h4000_0000);
      2:       step = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
      3:       step = 32'h8000_0000;
      default: step = $urandom;
    endcase
    case ($urandom_range(0, 4))
      0:       depth_val = 32'd0;
      1:       depth_val = {16'd0, DEPTH_MAX};
      2:       depth_val = $urandom_range(32769, 65535);
      default: depth_val = $urandom_range(0, 32768);
    endcase
    write_reg(REG_WAVE_SELECT, $urandom_range(0, 7));
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_START_PHASE, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
    write_reg(REG_DEPTH, depth_val);
    case ($urandom_range(0, 4))
      0:       write_reg(REG_CENTER, 32'd0);
      1:       write_reg(REG_CENTER, 32'h0000_FFFF);
      default: write_reg(REG_CENTER, $urandom);
    endcase
    write_reg(REG_SEED, $urandom);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    end
  endtask

  // result side
  initial begin
    osc_result_t exp_res;
    int          hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        if (osc_results_due.size() == 0) begin
          $error("result beat with nothing outstanding: tdata %h", m_axis_tdata);
          mismatch_count++;
        end else begin
          exp_res = osc_results_due.pop_front();
          if (m_axis_tdata[15:0] !== exp_res.level) begin
            $error("level: expected %0d, actual %0d", exp_res.level, m_axis_tdata[15:0]);
            mismatch_count++;
          end
          if (m_axis_tdata[16] !== exp_res.cycle_wrapped) begin
            $error("cycle_wrapped: expected %0d, actual %0d", exp_res.cycle_wrapped,
                   m_axis_tdata[16]);
            mismatch_count++;
          end
          if (m_axis_tdata[48:17] !== exp_res.cycle_number) begin
            $error("cycle_number: expected %0d, actual %0d", exp_res.cycle_number,
                   m_axis_tdata[48:17]);
            mismatch_count++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lfo_waveform_generator verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    osc_result_t blank;
    blank         = '{default: '0};
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    fill_quarter_wave();
    osc_reset();

    // after reset: sine at phase zero sits on the center
    add_known(1'b1, 16'd32768, 1'b0, 32'd0);
    add_tick(1'b0);
    // full depth square, both halves clamp
    add_write(REG_WAVE_SELECT, WAVE_SQUARE);
    add_write(REG_DEPTH, {16'd0, DEPTH_MAX});
    add_known(1'b1, 16'hFFFF, 1'b0, 32'd0);
    add_write(REG_START_PHASE, 32'h8000_0000);
    add_known(1'b1, 16'h0000, 1'b0, 32'd0);
    // quarter-cycle steps walk every triangle corner and wrap
    add_write(REG_WAVE_SELECT, WAVE_TRIANGLE);
    add_write(REG_PHASE_STEP, 32'h4000_0000);
    add_write(REG_START_PHASE, 32'd0);
    add_tick(1'b1);
    add_tick(1'b0);
    add_tick(1'b0);
    add_tick(1'b0);
    add_tick(1'b0);
    add_write(REG_WAVE_SELECT, WAVE_SAW);
    add_tick(1'b0);
    add_tick(1'b0);
    add_write(REG_WAVE_SELECT, WAVE_RAMP);
    add_tick(1'b0);
    add_tick(1'b0);
    // sample-and-hold, wrap on nearly every tick
    add_write(REG_WAVE_SELECT, WAVE_SH);
    add_write(REG_SEED, 32'hDEAD_BEEF);
    add_write(REG_PHASE_STEP, 32'hFFFF_FFFF);
    add_tick(1'b1);
    add_tick(1'b0);
    add_tick(1'b0);
    // new seed only shows after the next wrap, zero step never wraps
    add_write(REG_SEED, 32'h1234_5678);
    add_write(REG_PHASE_STEP, 32'd0);
    add_tick(1'b0);
    add_write(REG_PHASE_STEP, 32'hFFFF_FFFF);
    add_tick(1'b0);
    // unused wave codes give the center
    add_write(REG_WAVE_SELECT, WAVE_SPARE_LO);
    add_write(REG_CENTER, 32'h0000_1234);
    add_known(1'b1, 16'h1234, 1'b0, 32'd0);
    add_write(REG_WAVE_SELECT, WAVE_SPARE_HI);
    add_known(1'b1, 16'h1234, 1'b0, 32'd0);
    // writes past the map are dropped
    add_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    add_write(REG_SPARE_HI, 32'hFFFF_FFFF);
    add_write(REG_WAVE_SELECT, WAVE_SINE);
    add_write(REG_DEPTH, 32'd0);
    add_write(REG_CENTER, 32'd0);
    add_write(REG_PHASE_STEP, 32'd0);
    add_known(1'b1, 16'h0000, 1'b0, 32'd0);
    add_known(1'b0, 16'h0000, 1'b0, 32'd0);
    // depth above 32768 is clamped
    add_write(REG_DEPTH, 32'h0000_FFFF);
    add_write(REG_CENTER, 32'h0000_FFFF);
    add_write(REG_PHASE_STEP, 32'h0100_0000);
    add_write(REG_START_PHASE, 32'h3FFF_FFFF);
    add_tick(1'b1);
    add_tick(1'b0);
    add_tick(1'b0);

    send_idle_pct = 27;
    recv_idle_pct = 59;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        if (r == 0 || dir_rows[r - 1].kind != ROW_WRITE) begin
          wait_drained();
        end
        write_reg(dir_rows[r].reg_idx, dir_rows[r].wdata);
      end else begin
        send_tick(dir_rows[r].restart, dir_rows[r].kind == ROW_TICK_KNOWN, dir_rows[r].known);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 59;
        recv_idle_pct = 27;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      randomize_regs();
      // long output stall while ticks keep coming
      if (ph == 9) begin
        hold_request = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_tick($urandom_range(0, 99) < RESTART_PCT, 1'b0, blank);
      end
    end

    wait_drained();
    if (mismatch_count == 0 && osc_results_due.size() == 0) begin
      $display("lfo_waveform_generator verification clean");
    end else begin
      $display("lfo_waveform_generator verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lfo_pkg.sv
rtl/lfo_ram.sv
rtl/lfo_waveform_generator.sv
rtl/lfo_checker.sv
tb/tb_top.sv
